FILE: rtl/csam_pkg.sv
// ----------------------------------------------------------------------------
// csam_pkg
// shared types, constants and the finish-sequence program of the area moments
// core
// ----------------------------------------------------------------------------
`default_nettype none

package csam_pkg;

  // geometry default
  localparam int unsigned MaxSideDefault = 1024;

  // wide accumulator used by the finish sequence
  localparam int unsigned BigW     = 256;
  localparam int unsigned LimbW    = 32;
  localparam int unsigned NumLimbs = BigW / LimbW;
  localparam int unsigned LimbCntW = $clog2(NumLimbs);
  localparam int unsigned DivCntW  = $clog2(BigW);
  localparam int unsigned DshW     = 3 * LimbW;

  // configuration port
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 24;
  localparam logic [CfgIndexW-1:0] CfgColumnCount = 2'd0;
  localparam logic [CfgIndexW-1:0] CfgRowCount    = 2'd1;
  localparam logic [CfgIndexW-1:0] CfgPixelWidth  = 2'd2;
  localparam logic [CfgIndexW-1:0] CfgPixelHeight = 2'd3;

  localparam logic [10:0] SideCountReset = 11'd64;
  localparam logic [23:0] PixelSizeReset = 24'd65536;

  // saturation limits
  localparam logic [63:0] LimCentroid  = 64'h0000_0003_FFFF_FFFF;
  localparam logic [63:0] LimMoment    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] LimNegMoment = 64'h8000_0000_0000_0000;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCUM,
    OP_EMPTY,
    OP_CLEAR,
    OP_LOAD,
    OP_MUL,
    OP_SAVE,
    OP_SPREAD,
    OP_PREP,
    OP_DIV,
    OP_STORE
  } op_e;

  typedef logic [2:0] arg_t;

  // load sources
  localparam arg_t SrcN   = 3'd0;
  localparam arg_t SrcSx  = 3'd1;
  localparam arg_t SrcSy  = 3'd2;
  localparam arg_t SrcSxx = 3'd3;
  localparam arg_t SrcSyy = 3'd4;
  localparam arg_t SrcSxy = 3'd5;

  // multiplier sources
  localparam arg_t MulDx = 3'd0;
  localparam arg_t MulDy = 3'd1;
  localparam arg_t MulN  = 3'd2;
  localparam arg_t MulSx = 3'd3;
  localparam arg_t MulSy = 3'd4;

  // rounding divide setups: divisor and scale shift
  localparam arg_t PrepCentroid = 3'd0;
  localparam arg_t PrepArea     = 3'd1;
  localparam arg_t PrepMoment   = 3'd2;

  // result destinations
  localparam arg_t DstCx   = 3'd0;
  localparam arg_t DstCy   = 3'd1;
  localparam arg_t DstArea = 3'd2;
  localparam arg_t DstIx   = 3'd3;
  localparam arg_t DstIy   = 3'd4;
  localparam arg_t DstIxy  = 3'd5;

  typedef struct packed {
    op_e  op;
    arg_t arg;
  } instr_t;

  typedef struct packed {
    op_e  op;
    arg_t arg;
    logic pixel_set;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic frame_end;
    logic count_zero;
  } dp_status_t;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_CHECK,
    ST_ISSUE,
    ST_WAIT
  } ctrl_state_e;

  localparam int unsigned ProgLen  = 55;
  localparam int unsigned PcW      = 6;
  localparam int unsigned ProgLast = ProgLen - 1;

  // finish sequence, run once per non-empty frame
  function automatic instr_t program_rom(input logic [PcW-1:0] pc);
    instr_t r;
    case (pc)
      // centroid x
      6'd0:  r = '{OP_LOAD,   SrcSx};
      6'd1:  r = '{OP_MUL,    MulDx};
      6'd2:  r = '{OP_PREP,   PrepCentroid};
      6'd3:  r = '{OP_DIV,    arg_t'(0)};
      6'd4:  r = '{OP_STORE,  DstCx};
      // centroid y
      6'd5:  r = '{OP_LOAD,   SrcSy};
      6'd6:  r = '{OP_MUL,    MulDy};
      6'd7:  r = '{OP_PREP,   PrepCentroid};
      6'd8:  r = '{OP_DIV,    arg_t'(0)};
      6'd9:  r = '{OP_STORE,  DstCy};
      // area
      6'd10: r = '{OP_LOAD,   SrcN};
      6'd11: r = '{OP_MUL,    MulDx};
      6'd12: r = '{OP_MUL,    MulDy};
      6'd13: r = '{OP_PREP,   PrepArea};
      6'd14: r = '{OP_DIV,    arg_t'(0)};
      6'd15: r = '{OP_STORE,  DstArea};
      // ix
      6'd16: r = '{OP_LOAD,   SrcSyy};
      6'd17: r = '{OP_MUL,    MulN};
      6'd18: r = '{OP_SAVE,   arg_t'(0)};
      6'd19: r = '{OP_LOAD,   SrcSy};
      6'd20: r = '{OP_MUL,    MulSy};
      6'd21: r = '{OP_SPREAD, arg_t'(0)};
      6'd22: r = '{OP_MUL,    MulDx};
      6'd23: r = '{OP_MUL,    MulDy};
      6'd24: r = '{OP_MUL,    MulDy};
      6'd25: r = '{OP_MUL,    MulDy};
      6'd26: r = '{OP_PREP,   PrepMoment};
      6'd27: r = '{OP_DIV,    arg_t'(0)};
      6'd28: r = '{OP_STORE,  DstIx};
      // iy
      6'd29: r = '{OP_LOAD,   SrcSxx};
      6'd30: r = '{OP_MUL,    MulN};
      6'd31: r = '{OP_SAVE,   arg_t'(0)};
      6'd32: r = '{OP_LOAD,   SrcSx};
      6'd33: r = '{OP_MUL,    MulSx};
      6'd34: r = '{OP_SPREAD, arg_t'(0)};
      6'd35: r = '{OP_MUL,    MulDy};
      6'd36: r = '{OP_MUL,    MulDx};
      6'd37: r = '{OP_MUL,    MulDx};
      6'd38: r = '{OP_MUL,    MulDx};
      6'd39: r = '{OP_PREP,   PrepMoment};
      6'd40: r = '{OP_DIV,    arg_t'(0)};
      6'd41: r = '{OP_STORE,  DstIy};
      // ixy
      6'd42: r = '{OP_LOAD,   SrcSxy};
      6'd43: r = '{OP_MUL,    MulN};
      6'd44: r = '{OP_SAVE,   arg_t'(0)};
      6'd45: r = '{OP_LOAD,   SrcSx};
      6'd46: r = '{OP_MUL,    MulSy};
      6'd47: r = '{OP_SPREAD, arg_t'(0)};
      6'd48: r = '{OP_MUL,    MulDx};
      6'd49: r = '{OP_MUL,    MulDx};
      6'd50: r = '{OP_MUL,    MulDy};
      6'd51: r = '{OP_MUL,    MulDy};
      6'd52: r = '{OP_PREP,   PrepMoment};
      6'd53: r = '{OP_DIV,    arg_t'(0)};
      6'd54: r = '{OP_STORE,  DstIxy};
      default: r = '{OP_NONE, arg_t'(0)};
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/csam_dp.sv
// ----------------------------------------------------------------------------
// csam_dp
// datapath: configuration, running sums, wide multiply and serial divider
// ----------------------------------------------------------------------------
`default_nettype none

module csam_dp import csam_pkg::*; #(
  parameter int unsigned MAX_SIDE = MaxSideDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [CfgIndexW-1:0]          cfg_index_i,
  input  logic [CfgDataW-1:0]           cfg_data_i,
  input  dp_cmd_t                       cmd_i,
  output dp_status_t                    status_o,
  output logic [2*$clog2(MAX_SIDE):0]   active_count_o,
  output logic [33:0]                   centroid_x_o,
  output logic [33:0]                   centroid_y_o,
  output logic [62:0]                   section_area_o,
  output logic [62:0]                   moment_about_x_o,
  output logic [62:0]                   moment_about_y_o,
  output logic signed [63:0]            product_moment_o,
  output logic                          empty_section_o
);

  localparam int unsigned PW    = $clog2(MAX_SIDE);
  localparam int unsigned SW    = $clog2(MAX_SIDE + 1);
  localparam int unsigned HW    = PW + 1;
  localparam int unsigned CW    = 2 * PW + 1;
  localparam int unsigned S1W   = CW + HW;
  localparam int unsigned S2W   = CW + 2 * HW;
  localparam int unsigned SPW   = 2 * S1W;
  localparam int unsigned MW    = (S1W > 24) ? S1W : 24;
  localparam int unsigned DW    = CW + 2;
  localparam int unsigned ProdW = LimbW + MW;
  localparam logic [12:0] MaxSideW = 13'(MAX_SIDE);

  // configuration
  logic [10:0] column_count_q, row_count_q;
  logic [23:0] pixel_width_q, pixel_height_q;

  // frame state
  logic [PW-1:0]  col_q, row_q;
  logic [CW-1:0]  cnt_q;
  logic [S1W-1:0] sx_q, sy_q;
  logic [S2W-1:0] sxx_q, syy_q, sxy_q;

  // sequencing
  logic                busy_q, div_mode_q;
  logic [LimbCntW-1:0] mcnt_q;
  logic [DivCntW-1:0]  div_left_q, div_len_q;

  // arithmetic
  logic [BigW-1:0] p_q;
  logic [SPW-1:0]  s_q;
  logic [MW-1:0]   m_q, carry_q;
  logic            add_en_q;
  logic [DW-1:0]   d_q, rem_q;
  logic [DshW-1:0] dsh_q;
  logic [63:0]     quo_q;
  logic            ovf_q, neg_q;

  logic [CW-1:0]           active_q;
  logic [33:0]             cx_q, cy_q;
  logic [62:0]             area_q, ix_q, iy_q;
  logic [63:0]             ixy_q;
  logic                    empty_q;

  logic [SW-1:0]   cols, rows, col_inc, row_inc;
  logic            col_wrap, row_wrap, frame_clear;
  logic [HW-1:0]   hx, hy;
  logic [2*HW-1:0] hxx, hyy, hxy;

  always_comb begin
    if (column_count_q == '0) begin
      cols = SW'(1);
    end else if ({2'b00, column_count_q} > MaxSideW) begin
      cols = SW'(MAX_SIDE);
    end else begin
      cols = SW'(column_count_q);
    end
    if (row_count_q == '0) begin
      rows = SW'(1);
    end else if ({2'b00, row_count_q} > MaxSideW) begin
      rows = SW'(MAX_SIDE);
    end else begin
      rows = SW'(row_count_q);
    end
  end

  assign col_inc  = SW'(col_q) + SW'(1);
  assign row_inc  = SW'(row_q) + SW'(1);
  assign col_wrap = (col_inc >= cols);
  assign row_wrap = (row_inc >= rows);

  // pixel centres in half-pixel units
  assign hx  = {col_q, 1'b1};
  assign hy  = {row_q, 1'b1};
  assign hxx = hx * hx;
  assign hyy = hy * hy;
  assign hxy = hx * hy;

  assign frame_clear = cfg_we_i || (cmd_i.op == OP_EMPTY) || (cmd_i.op == OP_CLEAR);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= SideCountReset;
      row_count_q    <= SideCountReset;
      pixel_width_q  <= PixelSizeReset;
      pixel_height_q <= PixelSizeReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgColumnCount: column_count_q <= cfg_data_i[10:0];
        CfgRowCount:    row_count_q    <= cfg_data_i[10:0];
        CfgPixelWidth:  pixel_width_q  <= cfg_data_i;
        CfgPixelHeight: pixel_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
    end else if (frame_clear) begin
      col_q <= '0;
      row_q <= '0;
      cnt_q <= '0;
      sx_q  <= '0;
      sy_q  <= '0;
      sxx_q <= '0;
      syy_q <= '0;
      sxy_q <= '0;
    end else if (cmd_i.op == OP_ACCUM) begin
      if (cmd_i.pixel_set) begin
        cnt_q <= cnt_q + CW'(1);
        sx_q  <= sx_q + S1W'(hx);
        sy_q  <= sy_q + S1W'(hy);
        sxx_q <= sxx_q + S2W'(hxx);
        syy_q <= syy_q + S2W'(hyy);
        sxy_q <= sxy_q + S2W'(hxy);
      end
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : PW'(row_inc);
      end else begin
        col_q <= PW'(col_inc);
      end
    end
  end

  // operand selection
  logic [BigW-1:0] load_val;
  logic [MW-1:0]   mul_val;
  logic [DW-1:0]   prep_d;
  logic [5:0]      prep_shift;

  always_comb begin
    case (cmd_i.arg)
      SrcN:    load_val = BigW'(cnt_q);
      SrcSx:   load_val = BigW'(sx_q);
      SrcSy:   load_val = BigW'(sy_q);
      SrcSxx:  load_val = BigW'(sxx_q);
      SrcSyy:  load_val = BigW'(syy_q);
      SrcSxy:  load_val = BigW'(sxy_q);
      default: load_val = '0;
    endcase
    case (cmd_i.arg)
      MulDx:   mul_val = MW'(pixel_width_q);
      MulDy:   mul_val = MW'(pixel_height_q);
      MulN:    mul_val = MW'(cnt_q);
      MulSx:   mul_val = MW'(sx_q);
      MulSy:   mul_val = MW'(sy_q);
      default: mul_val = '0;
    endcase
    case (cmd_i.arg)
      PrepCentroid: begin
        prep_d     = DW'({cnt_q, 1'b0});
        prep_shift = 6'd0;
      end
      PrepArea: begin
        prep_d     = DW'(1);
        prep_shift = 6'd16;
      end
      PrepMoment: begin
        prep_d     = {cnt_q, 2'b00};
        prep_shift = 6'd48;
      end
      default: begin
        prep_d     = DW'(1);
        prep_shift = 6'd0;
      end
    endcase
  end

  // one limb per cycle: limb * m + carry, plus the rounding term when preparing
  logic [LimbW-1:0] addend;
  logic [ProdW-1:0] prod;

  always_comb begin
    case (mcnt_q)
      3'd0:    addend = dsh_q[LimbW-1:0];
      3'd1:    addend = dsh_q[2*LimbW-1:LimbW];
      3'd2:    addend = dsh_q[3*LimbW-1:2*LimbW];
      default: addend = '0;
    endcase
    if (!add_en_q) begin
      addend = '0;
    end
  end

  assign prod = ProdW'(p_q[LimbW-1:0]) * ProdW'(m_q) + ProdW'(carry_q) + ProdW'(addend);

  // restoring division, one quotient bit per cycle
  logic [DW:0]   r2;
  logic          q_bit;
  logic [DW-1:0] rem_nx;

  assign r2     = {rem_q, p_q[BigW-1]};
  assign q_bit  = (r2 >= {1'b0, d_q});
  assign rem_nx = q_bit ? DW'(r2 - {1'b0, d_q}) : DW'(r2);

  // saturation for the store step
  logic [63:0]    lim, qsat;
  logic [SPW-1:0] p_low;
  logic           s_gt;

  always_comb begin
    if (cmd_i.arg == DstCx || cmd_i.arg == DstCy) begin
      lim = LimCentroid;
    end else if (cmd_i.arg == DstIxy && neg_q) begin
      lim = LimNegMoment;
    end else begin
      lim = LimMoment;
    end
    qsat = (ovf_q || (quo_q > lim)) ? lim : quo_q;
  end

  assign p_low = p_q[SPW-1:0];
  assign s_gt  = (s_q > p_low);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      div_mode_q <= 1'b0;
      mcnt_q     <= '0;
      div_left_q <= '0;
      div_len_q  <= '0;
    end else if (busy_q) begin
      if (div_mode_q) begin
        div_left_q <= div_left_q - DivCntW'(1);
        if (div_left_q == DivCntW'(1)) begin
          busy_q <= 1'b0;
        end
      end else begin
        mcnt_q <= mcnt_q + LimbCntW'(1);
        if (mcnt_q == LimbCntW'(NumLimbs - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end else begin
      case (cmd_i.op)
        OP_MUL, OP_PREP: begin
          busy_q     <= 1'b1;
          div_mode_q <= 1'b0;
          mcnt_q     <= '0;
          if (cmd_i.op == OP_PREP) begin
            div_len_q <= DivCntW'(BigW - 1) - DivCntW'(prep_shift);
          end
        end
        OP_DIV: begin
          busy_q     <= 1'b1;
          div_mode_q <= 1'b1;
          div_left_q <= div_len_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      if (div_mode_q) begin
        p_q   <= p_q << 1;
        rem_q <= rem_nx;
        quo_q <= {quo_q[62:0], q_bit};
        ovf_q <= ovf_q | quo_q[63];
      end else begin
        p_q     <= {prod[LimbW-1:0], p_q[BigW-1:LimbW]};
        carry_q <= prod[ProdW-1:LimbW];
      end
    end else begin
      case (cmd_i.op)
        OP_LOAD: p_q <= load_val;
        OP_MUL: begin
          m_q      <= mul_val;
          carry_q  <= '0;
          add_en_q <= 1'b0;
        end
        OP_SAVE: s_q <= p_low;
        OP_SPREAD: begin
          // n*sq - a*b as a magnitude and a sign
          p_q   <= s_gt ? BigW'(s_q - p_low) : BigW'(p_low - s_q);
          neg_q <= !s_gt;
        end
        OP_PREP: begin
          // 2p + d*2^s, then shifted down by s+1 inside the divide
          m_q      <= MW'(2);
          carry_q  <= '0;
          add_en_q <= 1'b1;
          d_q      <= prep_d;
          dsh_q    <= DshW'(prep_d) << prep_shift;
        end
        OP_DIV: begin
          rem_q <= '0;
          quo_q <= '0;
          ovf_q <= 1'b0;
        end
        OP_STORE: begin
          case (cmd_i.arg)
            DstCx: begin
              cx_q     <= qsat[33:0];
              active_q <= cnt_q;
              empty_q  <= 1'b0;
            end
            DstCy:   cy_q   <= qsat[33:0];
            DstArea: area_q <= qsat[62:0];
            DstIx:   ix_q   <= neg_q ? '0 : qsat[62:0];
            DstIy:   iy_q   <= neg_q ? '0 : qsat[62:0];
            DstIxy:  ixy_q  <= neg_q ? (64'd0 - qsat) : qsat;
            default: ;
          endcase
        end
        OP_EMPTY: begin
          active_q <= '0;
          cx_q     <= '0;
          cy_q     <= '0;
          area_q   <= '0;
          ix_q     <= '0;
          iy_q     <= '0;
          ixy_q    <= '0;
          empty_q  <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign status_o = '{busy: busy_q, frame_end: col_wrap && row_wrap,
                      count_zero: (cnt_q == '0)};

  assign active_count_o   = active_q;
  assign centroid_x_o     = cx_q;
  assign centroid_y_o     = cy_q;
  assign section_area_o   = area_q;
  assign moment_about_x_o = ix_q;
  assign moment_about_y_o = iy_q;
  assign product_moment_o = ixy_q;
  assign empty_section_o  = empty_q;

endmodule

`default_nettype wire

FILE: rtl/csam_ctrl.sv
// ----------------------------------------------------------------------------
// csam_ctrl
// controller: pixel intake, finish-sequence program counter, result valid
// ----------------------------------------------------------------------------
`default_nettype none

module csam_ctrl import csam_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       pixel_set_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  ctrl_state_e      state_q, state_d;
  logic [PcW-1:0]   pc_q, pc_d;
  logic             out_valid_q, out_valid_d;
  instr_t           instr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_ACCUM;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign instr = program_rom(pc_q);

  always_comb begin
    state_d     = state_q;
    pc_d        = pc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '{op: OP_NONE, arg: arg_t'(0), pixel_set: 1'b0};
    case (state_q)
      ST_ACCUM: begin
        // the last pixel of a frame waits until the result slot is free
        in_ready_o = !(status_i.frame_end && out_valid_q);
        if (in_valid_i && in_ready_o) begin
          cmd_o.op        = OP_ACCUM;
          cmd_o.pixel_set = pixel_set_i;
          if (status_i.frame_end) begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (status_i.count_zero) begin
          cmd_o.op    = OP_EMPTY;
          out_valid_d = 1'b1;
          state_d     = ST_ACCUM;
        end else begin
          pc_d    = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        cmd_o.op  = instr.op;
        cmd_o.arg = instr.arg;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (!status_i.busy) begin
          if (pc_q == PcW'(ProgLast)) begin
            cmd_o.op    = OP_CLEAR;
            out_valid_d = 1'b1;
            state_d     = ST_ACCUM;
          end else begin
            pc_d    = pc_q + PcW'(1);
            state_d = ST_ISSUE;
          end
        end
      end
      default: state_d = ST_ACCUM;
    endcase
  end

  assign out_valid_o = out_valid_q;

  // the finish sequence only writes the result registers while they are free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE) |-> !out_valid_q)
    else $error("finish sequence runs while a result is pending");

  // completing the last instruction presents a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT && !status_i.busy && pc_q == PcW'(ProgLast)) |=> out_valid_o)
    else $error("no result after finish sequence");

  // program counter stays inside the program
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE || state_q == ST_WAIT) |-> (pc_q <= PcW'(ProgLast)))
    else $error("program counter out of range");

  // no pixel is taken while the finish sequence runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK || state_q == ST_ISSUE || state_q == ST_WAIT) |-> !in_ready_o)
    else $error("pixel accepted during finish sequence");

endmodule

`default_nettype wire

FILE: rtl/cross_section_area_moments_core.sv
// ----------------------------------------------------------------------------
// cross_section_area_moments_core
// area, centroid and central second moments of a binary cross-section bitmap
// ----------------------------------------------------------------------------
// pixels arrive one per word in raster order, bottom row first, and are taken
// at one per clock while no finish sequence runs; each set pixel adds its
// half-pixel centre coordinates, their squares and their product to running
// sums. the word that completes a frame starts a finish sequence on a shared
// 256-bit accumulator: limb-serial multiplies (32 bits a cycle) and a
// bit-serial rounding divider (one quotient bit a cycle). in a non-empty
// frame almost all of the finish sequence is spent in the six divides; an
// empty frame skips it. the next frame's pixels are taken while a result
// word waits, only a frame's last pixel is held back until the previous
// result has been taken. a configuration write restarts the current frame
// and is meant for idle time.
// ----------------------------------------------------------------------------
`default_nettype none

module cross_section_area_moments_core import csam_pkg::*; #(
  parameter int unsigned MAX_SIDE = MaxSideDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic [CfgIndexW-1:0]        cfg_index_i,
  input  logic [CfgDataW-1:0]         cfg_data_i,
  // pixel words
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        pixel_set_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2*$clog2(MAX_SIDE):0] active_count_o,
  output logic [33:0]                 centroid_x_o,
  output logic [33:0]                 centroid_y_o,
  output logic [62:0]                 section_area_o,
  output logic [62:0]                 moment_about_x_o,
  output logic [62:0]                 moment_about_y_o,
  output logic signed [63:0]          product_moment_o,
  output logic                        empty_section_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing: intake, program counter and result valid
  csam_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_set_i (pixel_set_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // sums, wide arithmetic and result registers
  csam_dp #(
    .MAX_SIDE (MAX_SIDE)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .active_count_o   (active_count_o),
    .centroid_x_o     (centroid_x_o),
    .centroid_y_o     (centroid_y_o),
    .section_area_o   (section_area_o),
    .moment_about_x_o (moment_about_x_o),
    .moment_about_y_o (moment_about_y_o),
    .product_moment_o (product_moment_o),
    .empty_section_o  (empty_section_o)
  );

endmodule

`default_nettype wire

FILE: tb/sv/cross_section_area_moments_checker.sv
// ----------------------------------------------------------------------------
// cross_section_area_moments_checker
// watches the pixel, result and register ports and checks every result word
// ----------------------------------------------------------------------------
// keeps its own copy of the geometry registers, the raster position and the
// coordinate sums; a word that ends a frame pushes the expected moments, and
// each result word taken from the core is compared with the oldest of them
// ----------------------------------------------------------------------------
module cross_section_area_moments_checker import csam_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 pixel_set_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [20:0]          active_count_i,
  input  logic [33:0]          centroid_x_i,
  input  logic [33:0]          centroid_y_i,
  input  logic [62:0]          section_area_i,
  input  logic [62:0]          moment_about_x_i,
  input  logic [62:0]          moment_about_y_i,
  input  logic signed [63:0]   product_moment_i,
  input  logic                 empty_section_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [319:0] wide_t;

  typedef struct {
    logic [20:0]        cnt;
    logic [33:0]        cx;
    logic [33:0]        cy;
    logic [62:0]        area;
    logic [62:0]        ix;
    logic [62:0]        iy;
    logic signed [63:0] ixy;
    logic               empty;
  } moments_t;

  moments_t    moments_q[$];
  logic [10:0] col_cnt, row_cnt;
  logic [23:0] dx, dy;
  int unsigned col_pos, row_pos;
  logic [63:0] n_set, sx, sy, sxx, syy, sxy;

  assign pending_o = moments_q.size();

  function automatic int unsigned clamp_side(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  // rounded quotient p / (d * 2^s), halves up, clipped at lim
  function automatic logic [63:0] round_quot(wide_t p, int unsigned s, wide_t d,
                                             logic [63:0] lim);
    wide_t q;
    q = (((p << 1) + (d << s)) >> (s + 1)) / d;
    if (q > wide_t'(lim)) return lim;
    return q[63:0];
  endfunction

  // n*sq - a*b as a magnitude with its sign; zero counts as negative
  function automatic wide_t spread(logic [63:0] n, logic [63:0] sq, logic [63:0] a,
                                   logic [63:0] b, output bit neg);
    wide_t l, r;
    l = wide_t'(n) * wide_t'(sq);
    r = wide_t'(a) * wide_t'(b);
    neg = !(l > r);
    return neg ? r - l : l - r;
  endfunction

  function automatic moments_t frame_moments();
    moments_t m;
    wide_t    p, wx, wy, d4;
    bit       neg;
    m = '{default: '0};
    if (n_set == 0) begin
      m.empty = 1'b1;
      return m;
    end
    wx = wide_t'(dx);
    wy = wide_t'(dy);
    d4 = wide_t'(4 * n_set);
    m.cnt  = n_set[20:0];
    m.cx   = 34'(round_quot(wx * sx, 0, 2 * n_set, LimCentroid));
    m.cy   = 34'(round_quot(wy * sy, 0, 2 * n_set, LimCentroid));
    m.area = 63'(round_quot(wide_t'(n_set) * wx * wy, 16, 1, LimMoment));
    p = spread(n_set, syy, sy, sy, neg) * wx * wy * wy * wy;
    m.ix = neg ? '0 : 63'(round_quot(p, 48, d4, LimMoment));
    p = spread(n_set, sxx, sx, sx, neg) * wy * wx * wx * wx;
    m.iy = neg ? '0 : 63'(round_quot(p, 48, d4, LimMoment));
    p = spread(n_set, sxy, sx, sy, neg) * wx * wx * wy * wy;
    if (neg) m.ixy = -$signed(round_quot(p, 48, d4, LimNegMoment));
    else     m.ixy = $signed(round_quot(p, 48, d4, LimMoment));
    return m;
  endfunction

  task automatic clear_sums();
    col_pos = 0; row_pos = 0;
    n_set = 0; sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
  endtask

  task automatic mismatch(string what, logic [63:0] exp_v, logic [63:0] act_v);
    errors_o++;
    $display("%0t mismatch %s expected %0h actual %0h", $time, what, exp_v, act_v);
  endtask

  // everything the testbench drives changes at the rising edge, so the
  // falling edge sees the values that the next rising edge will act on
  always @(negedge clk_i or negedge rst_ni) begin
    moments_t    m;
    logic [63:0] hx, hy;
    int unsigned cols, rows;
    bit          last;
    if (!rst_ni) begin
      col_cnt = SideCountReset; row_cnt = SideCountReset;
      dx = PixelSizeReset; dy = PixelSizeReset;
      clear_sums();
      moments_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgColumnCount: col_cnt = cfg_data_i[10:0];
          CfgRowCount:    row_cnt = cfg_data_i[10:0];
          CfgPixelWidth:  dx = cfg_data_i;
          CfgPixelHeight: dy = cfg_data_i;
          default: ;
        endcase
        clear_sums();
      end
      if (in_valid_i && in_ready_i) begin
        cols = clamp_side(col_cnt);
        rows = clamp_side(row_cnt);
        if (pixel_set_i) begin
          hx = 2 * col_pos + 1;
          hy = 2 * row_pos + 1;
          n_set++;
          sx += hx; sy += hy;
          sxx += hx * hx; syy += hy * hy; sxy += hx * hy;
        end
        last = (col_pos + 1 >= cols) && (row_pos + 1 >= rows);
        col_pos++;
        if (col_pos >= cols) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= rows) row_pos = 0;
        end
        if (last) begin
          moments_q.push_back(frame_moments());
          clear_sums();
        end
      end
      if (out_valid_i && out_ready_i) begin
        if (moments_q.size() == 0) begin
          errors_o++;
          $display("%0t result word with nothing expected, count %0d", $time,
                   active_count_i);
        end else begin
          m = moments_q.pop_front();
          if (active_count_i !== m.cnt)    mismatch("active_count", m.cnt, active_count_i);
          if (centroid_x_i !== m.cx)       mismatch("centroid_x", m.cx, centroid_x_i);
          if (centroid_y_i !== m.cy)       mismatch("centroid_y", m.cy, centroid_y_i);
          if (section_area_i !== m.area)   mismatch("section_area", m.area, section_area_i);
          if (moment_about_x_i !== m.ix)   mismatch("moment_about_x", m.ix, moment_about_x_i);
          if (moment_about_y_i !== m.iy)   mismatch("moment_about_y", m.iy, moment_about_y_i);
          if (product_moment_i !== m.ixy)  mismatch("product_moment", m.ixy, product_moment_i);
          if (empty_section_i !== m.empty) mismatch("empty_section", m.empty, empty_section_i);
        end
      end
    end
  end

  initial errors_o = 0;

endmodule

FILE: tb/sv/cross_section_area_moments_core_tb.sv
// ----------------------------------------------------------------------------
// cross_section_area_moments_core_tb
// stimulus and verdict for the area moments core
// ----------------------------------------------------------------------------
// feeds bitmap frames under many geometries and pixel sizes, some of them cut
// short by a register write, with idle and stall patterns on both channels;
// the checker beside the core predicts and compares every result word
// ----------------------------------------------------------------------------
module cross_section_area_moments_core_tb;
  import csam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CfgIndexW-1:0] cfg_index = CfgColumnCount;
  logic [CfgDataW-1:0]  cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 pixel_set = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [20:0]          active_count;
  logic [33:0]          centroid_x, centroid_y;
  logic [62:0]          section_area, moment_about_x, moment_about_y;
  logic signed [63:0]   product_moment;
  logic                 empty_section;
  int                   errors, pending;

  // idle percentages of sender and receiver for the current phase
  int unsigned src_idle = 0;
  int unsigned sink_stall = 0;
  // long receiver hold-off, requested by toggling hold_kick
  logic        hold_kick = 1'b0;
  logic        hold_seen;
  int unsigned hold_left;
  int unsigned words_sent = 0;
  int unsigned frames_done = 0;

  always #10 clk = ~clk;

  cross_section_area_moments_core u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .pixel_set_i     (pixel_set),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .active_count_o  (active_count),
    .centroid_x_o    (centroid_x),
    .centroid_y_o    (centroid_y),
    .section_area_o  (section_area),
    .moment_about_x_o(moment_about_x),
    .moment_about_y_o(moment_about_y),
    .product_moment_o(product_moment),
    .empty_section_o (empty_section)
  );

  cross_section_area_moments_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .pixel_set_i     (pixel_set),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .active_count_i  (active_count),
    .centroid_x_i    (centroid_x),
    .centroid_y_i    (centroid_y),
    .section_area_i  (section_area),
    .moment_about_x_i(moment_about_x),
    .moment_about_y_i(moment_about_y),
    .product_moment_i(product_moment),
    .empty_section_i (empty_section),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_kick != hold_seen) begin
      hold_seen <= hold_kick;
      hold_left <= 6000;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall);
    end
  end

  function automatic int unsigned clamp_side(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  // one pixel word; valid only drops when an idle cycle is inserted
  task automatic send_pixel(logic b);
    logic rdy;
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    pixel_set <= b;
    do begin
      @(negedge clk);
      rdy = in_ready;
      @(posedge clk);
    end while (!rdy);
    words_sent++;
  endtask

  // registers are written only once the core is drained and quiet
  task automatic set_geometry(logic [10:0] cols, logic [10:0] rows,
                              logic [23:0] w, logic [23:0] h);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (50) @(posedge clk);
    cfg_we <= 1'b1;
    // upper bits of the count registers are ignored, fill them randomly
    cfg_index <= CfgColumnCount; cfg_data <= {13'($urandom), cols}; @(posedge clk);
    cfg_index <= CfgRowCount;    cfg_data <= {13'($urandom), rows}; @(posedge clk);
    cfg_index <= CfgPixelWidth;  cfg_data <= w;                     @(posedge clk);
    cfg_index <= CfgPixelHeight; cfg_data <= h;                     @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // pattern: 0 random at the given density, 1 full, 2 empty, 3 checkerboard
  task automatic send_frame(int unsigned npix, int unsigned pattern, int unsigned density);
    logic b;
    for (int unsigned i = 0; i < npix; i++) begin
      case (pattern)
        1:       b = 1'b1;
        2:       b = 1'b0;
        3:       b = i[0] ^ i[3];
        default: b = ($urandom_range(99) < density);
      endcase
      send_pixel(b);
    end
    frames_done++;
  endtask

  function automatic logic [23:0] pick_size();
    case ($urandom_range(7))
      0:       return 24'd1;
      1:       return 24'hFFFFFF;
      2:       return 24'd0;
      3:       return PixelSizeReset;
      4:       return 24'($urandom_range(255) << 16);
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [10:0] c, r;
    int unsigned phase;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    set_geometry(11'd2, 11'd2, PixelSizeReset, PixelSizeReset);
    send_frame(4, 1, 0);                           // full section
    send_frame(4, 2, 0);                           // empty section
    set_geometry(11'd1, 11'd1, 24'hFFFFFF, 24'hFFFFFF);
    send_frame(1, 1, 0);                           // one pixel, largest size
    send_frame(1, 2, 0);
    set_geometry(11'd0, 11'd0, 24'd0, 24'd1);      // zero counts act as one
    send_frame(1, 1, 0);                           // zero width
    set_geometry(11'd3, 11'd2, 24'd1, 24'd1);
    send_frame(2, 1, 0);                           // abandoned by the next write
    set_geometry(11'd3, 11'd2, 24'd1, 24'd1);
    send_frame(6, 3, 0);

    // geometry extremes: one long row and one tall column
    set_geometry(11'h7FF, 11'd1, pick_size(), pick_size());
    send_frame(1024, 0, 50);
    set_geometry(11'd1, 11'h400, pick_size(), pick_size());
    send_frame(1024, 0, 30);

    // receiver holds off while small frames keep coming, the core backs up
    set_geometry(11'd2, 11'd2, pick_size(), pick_size());
    hold_kick <= ~hold_kick;
    repeat (8) send_frame(4, 0, 60);
    in_valid <= 1'b0;
    wait (pending == 0);

    // random part, idle pattern changes with each phase
    phase = 0;
    words_sent = 0;
    frames_done = 0;
    while (words_sent < 600 || frames_done < 60) begin
      case (phase % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 52; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 52; end
        default: begin src_idle = 11; sink_stall = 11; end
      endcase
      c = 11'($urandom_range(1, 6));
      r = 11'($urandom_range(1, 6));
      if ($urandom_range(9) == 0) c = 11'($urandom_range(7, 24));
      set_geometry(c, r, pick_size(), pick_size());
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(9))
          0:       send_frame(c * r, 2, 0);
          1:       send_frame(c * r, 1, 0);
          default: send_frame(c * r, 0, $urandom_range(5, 95));
        endcase
      end
      // now and then a broken frame that a register write throws away
      if ($urandom_range(7) == 0 && c * r > 1)
        send_frame($urandom_range(1, c * r - 1), 0, 50);
      phase++;
    end

    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (2000) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #60ms;
    $display("FAILURE");
    $finish;
  end

endmodule
